>>> src/fpsqrt_pkg.sv
// ----------------------------------------------------------------------------
// fpsqrt_pkg
// Widths, register reset value and the stage record shared by the
// fixed-point square root pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package fpsqrt_pkg;

  localparam int WIDTH      = 32;
  localparam int VAL_W      = WIDTH - 1;
  localparam int FRAC_W     = 5;
  localparam int FRAC_RESET = 16;
  // largest even fraction count that still fits the word
  localparam int FRAC_LIM   = ((WIDTH - 2) / 2) * 2;
  // one root bit per step, enough steps for the widest scaled radicand
  localparam int NSTEPS     = (WIDTH + FRAC_LIM) / 2;
  localparam int RAD_W      = 2 * NSTEPS;
  localparam int ROOT_W     = NSTEPS;
  localparam int REM_W      = NSTEPS + 2;

  typedef logic [VAL_W-1:0]  val_t;
  typedef logic [FRAC_W-1:0] frac_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;   // scaled radicand, next pair at the top
    logic [REM_W-1:0]  rem;   // partial remainder
    logic [ROOT_W-1:0] root;  // root bits found so far
  } stage_t;

endpackage

`default_nettype wire

>>> src/fpsqrt_scale.sv
// ----------------------------------------------------------------------------
// fpsqrt_scale
// Holds the fraction count register and forms radicand * 2^fe in the entry
// stage of the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module fpsqrt_scale (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     cfg_wr_en,
  input  wire fpsqrt_pkg::frac_t  cfg_wr_data,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire fpsqrt_pkg::val_t   in_radicand,
  output logic                    out_valid,
  input  wire                     out_ready,
  output fpsqrt_pkg::stage_t      out_data
);
  import fpsqrt_pkg::*;

  frac_t  frac_r;
  frac_t  fe_eff;
  logic   valid_r;
  logic   valid_nxt;
  stage_t data_r;
  stage_t data_nxt;

  // odd counts round down to even, then clamp to the word
  always_comb begin
    fe_eff = {frac_r[FRAC_W-1:1], 1'b0};
    if (int'(fe_eff) > FRAC_LIM) begin
      fe_eff = FRAC_W'(FRAC_LIM);
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    data_nxt.rad  = RAD_W'(in_radicand) << fe_eff;
    data_nxt.rem  = '0;
    data_nxt.root = '0;
    valid_nxt     = in_ready ? in_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frac_r  <= FRAC_W'(FRAC_RESET);
      valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        frac_r <= cfg_wr_data;
      end
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

>>> src/fpsqrt_step.sv
// ----------------------------------------------------------------------------
// fpsqrt_step
// One restoring step: bring down a radicand bit pair, try 4*root+1, and
// register the new root bit with the item.
// ----------------------------------------------------------------------------
`default_nettype none

module fpsqrt_step (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire fpsqrt_pkg::stage_t in_data,
  output logic                    out_valid,
  input  wire                     out_ready,
  output fpsqrt_pkg::stage_t      out_data
);
  import fpsqrt_pkg::*;

  logic             valid_r;
  logic             valid_nxt;
  stage_t           data_r;
  stage_t           data_nxt;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             take;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    rem_sh        = {in_data.rem[REM_W-3:0], in_data.rad[RAD_W-1 -: 2]};
    trial         = {in_data.root, 2'b01};
    take          = rem_sh >= trial;
    data_nxt.rad  = in_data.rad << 2;
    data_nxt.rem  = take ? rem_sh - trial : rem_sh;
    data_nxt.root = {in_data.root[ROOT_W-2:0], take};
    valid_nxt     = in_ready ? in_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

>>> src/fixed_point_square_root.sv
// ----------------------------------------------------------------------------
// fixed_point_square_root
// Pipelined fixed-point square root, root = floor(sqrt(radicand * 2^fe)).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries in_radicand; result channel
//   out_valid/out_ready carries out_root in the same fixed-point format.
//   cfg_wr_en/cfg_wr_data write the fraction count (reset value 16); odd
//   counts are rounded down to even. Write it only while no item is in
//   flight.
//   Pipeline: one entry stage for the scaling shift, then one stage per root
//   bit, each holding one remainder subtract and compare.
//   Throughput: one item per cycle, sustained while the receiver keeps
//   out_ready high.
//   Reset (rst_n low, synchronous) empties every stage and restores the
//   fraction count; data in flight is dropped.
//   When the receiver stalls, the last stage holds its item and stages behind
//   it keep filling bubbles; in_ready drops only once every stage is full.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_square_root (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     cfg_wr_en,
  input  wire fpsqrt_pkg::frac_t  cfg_wr_data,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire fpsqrt_pkg::val_t   in_radicand,
  output logic                    out_valid,
  input  wire                     out_ready,
  output fpsqrt_pkg::val_t        out_root
);
  import fpsqrt_pkg::*;

  stage_t [NSTEPS:0] sd;
  logic   [NSTEPS:0] sv;
  logic   [NSTEPS:0] sr;

  fpsqrt_scale u_scale (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_radicand (in_radicand),
    .out_valid   (sv[0]),
    .out_ready   (sr[0]),
    .out_data    (sd[0])
  );

  for (genvar i = 0; i < NSTEPS; i++) begin : g_step
    fpsqrt_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (sv[i]),
      .in_ready  (sr[i]),
      .in_data   (sd[i]),
      .out_valid (sv[i+1]),
      .out_ready (sr[i+1]),
      .out_data  (sd[i+1])
    );
  end

  assign sr[NSTEPS] = out_ready;
  assign out_valid  = sv[NSTEPS];
  assign out_root   = VAL_W'(sd[NSTEPS].root);

  // final remainder of a restoring root never exceeds twice the root
  a_rem_bound : assert property (@(posedge clk) disable iff (!rst_n)
    sv[NSTEPS] |-> (REM_W'(sd[NSTEPS].rem) <= REM_W'({sd[NSTEPS].root, 1'b0})))
    else $error("final remainder exceeds 2*root");

  // a full pipeline with a stalled receiver must push back
  a_full_stall : assert property (@(posedge clk) disable iff (!rst_n)
    (&sv && !out_ready) |-> !in_ready)
    else $error("input accepted into a full stalled pipeline");

  // an empty pipeline always takes an item
  a_empty_ready : assert property (@(posedge clk) disable iff (!rst_n)
    (sv == '0) |-> in_ready)
    else $error("empty pipeline not ready");

  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire
